@@ rtl/core/rvwap_pkg.sv @@
// Package for the running VWAP block: widths and shared types.
// Used by every file in rtl/core except rvwap_if.sv.
package rvwap_pkg;
  localparam int PRICE_WIDTH_DEF  = 24;
  localparam int VOLUME_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int PV_SUM_WIDTH     = 64;
  localparam int V_SUM_WIDTH      = 40;
endpackage

@@ rtl/core/rvwap_if.sv @@
// Valid/ready channel interfaces for bars and results.
// Depends on nothing.
interface rvwap_bar_if #(parameter int PW = 24, parameter int VW = 24);
  logic          valid;
  logic          ready;
  logic [PW-1:0] high_price;
  logic [PW-1:0] low_price;
  logic [PW-1:0] close_price;
  logic [VW-1:0] bar_volume;
  logic          first_bar;
  modport source(output valid, high_price, low_price, close_price, bar_volume, first_bar,
                 input ready);
  modport sink(input valid, high_price, low_price, close_price, bar_volume, first_bar,
               output ready);
endinterface

interface rvwap_res_if #(parameter int PW = 24, parameter int CW = 16);
  logic          valid;
  logic          ready;
  logic [PW-1:0] average_price;
  logic [CW-1:0] bars_in_range;
  modport source(output valid, average_price, bars_in_range, input ready);
  modport sink(input valid, average_price, bars_in_range, output ready);
endinterface

@@ rtl/core/rvwap_front.sv @@
// Front part: forms typical price times volume per bar and queues the bar.
// Depends on rvwap_pkg and rvwap_if.
module rvwap_front #(
  parameter int PRICE_WIDTH  = rvwap_pkg::PRICE_WIDTH_DEF,
  parameter int VOLUME_WIDTH = rvwap_pkg::VOLUME_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  rvwap_bar_if.sink bar,
  output logic q_valid,
  input  logic q_ready,
  output logic [PRICE_WIDTH+VOLUME_WIDTH-1:0] q_pv,
  output logic [VOLUME_WIDTH-1:0] q_vol,
  output logic q_first
);
  import rvwap_pkg::*;
  localparam int PVW = PRICE_WIDTH + VOLUME_WIDTH;
  localparam int EW = PVW + VOLUME_WIDTH + 1;
  localparam int RSH = PRICE_WIDTH + 4;
  localparam int RW = PRICE_WIDTH + 3;
  localparam int TPW = 2 * PRICE_WIDTH + 6;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RSH) + 64'd2) / 64'd3;

  logic [PRICE_WIDTH+1:0] psum;
  logic [TPW-1:0]         tprod;
  logic [PRICE_WIDTH+1:0] typical;
  logic                   s1_valid;
  logic [PRICE_WIDTH-1:0] s1_typ;
  logic [VOLUME_WIDTH-1:0] s1_vol;
  logic                   s1_first;
  logic                   s1_go;
  logic [EW-1:0]          fifo [2];
  logic [1:0]             cnt;
  logic                   wp, rp;
  logic                   push, pop;
  logic [EW-1:0]          head;

  assign psum = {2'b00, bar.high_price} + {2'b00, bar.low_price} + {2'b00, bar.close_price};
  // Division by three as a multiplication by the rounded-up reciprocal.
  assign tprod = TPW'(psum) * TPW'(RECIP_FULL[RW-1:0]);
  assign typical = tprod[RSH +: PRICE_WIDTH+2];
  // Stage 1 may advance when the queue will have room for it.
  assign s1_go = !s1_valid || (cnt < 2'd2) || pop;
  assign bar.ready = s1_go;
  assign push = s1_valid && s1_go;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go) begin
      s1_valid <= bar.valid;
    end
    if (s1_go) begin
      s1_typ   <= typical[PRICE_WIDTH-1:0];
      s1_vol   <= bar.bar_volume;
      s1_first <= bar.first_bar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) fifo[wp] <= {s1_first, s1_vol, PVW'(s1_typ) * PVW'(s1_vol)};
  end

  assign head = fifo[rp];
  assign q_valid = cnt != 2'd0;
  assign q_pv = head[PVW-1:0];
  assign q_vol = head[PVW+VOLUME_WIDTH-1:PVW];
  assign q_first = head[EW-1];
endmodule

@@ rtl/core/rvwap_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating to the price width.
// Depends on rvwap_pkg.
module rvwap_div #(
  parameter int PRICE_WIDTH = rvwap_pkg::PRICE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [rvwap_pkg::PV_SUM_WIDTH-1:0] dividend,
  input  logic [rvwap_pkg::V_SUM_WIDTH-1:0]  divisor,
  output logic done,
  output logic [PRICE_WIDTH-1:0] quotient
);
  import rvwap_pkg::*;
  localparam int CW = $clog2(PV_SUM_WIDTH + 1);

  logic [PV_SUM_WIDTH-1:0] num, quo;
  logic [V_SUM_WIDTH:0]    rem;
  logic [V_SUM_WIDTH-1:0]  den;
  logic [V_SUM_WIDTH:0]    trial;
  logic [CW-1:0]           left;
  logic                    busy;

  assign trial = {rem[V_SUM_WIDTH-1:0], num[PV_SUM_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (left == CW'(1));
      if (start) begin
        busy <= 1'b1;
        left <= CW'(PV_SUM_WIDTH);
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[PV_SUM_WIDTH-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[PV_SUM_WIDTH-2:0], 1'b0};
        end
        left <= left - CW'(1);
        if (left == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = (quo[PV_SUM_WIDTH-1:PRICE_WIDTH] != '0) ? '1 : quo[PRICE_WIDTH-1:0];
endmodule

@@ rtl/core/rvwap_back.sv @@
// Back part: running sums, bar count, divider control and the result register.
// Depends on rvwap_pkg, rvwap_if and rvwap_div.
module rvwap_back #(
  parameter int PRICE_WIDTH  = rvwap_pkg::PRICE_WIDTH_DEF,
  parameter int VOLUME_WIDTH = rvwap_pkg::VOLUME_WIDTH_DEF,
  parameter int COUNT_WIDTH  = rvwap_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  logic [PRICE_WIDTH+VOLUME_WIDTH-1:0] q_pv,
  input  logic [VOLUME_WIDTH-1:0] q_vol,
  input  logic q_first,
  rvwap_res_if.source res
);
  import rvwap_pkg::*;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]              state;
  logic [PV_SUM_WIDTH-1:0] pv_sum;
  logic [V_SUM_WIDTH-1:0]  v_sum;
  logic [PRICE_WIDTH-1:0]  last_avg;
  logic [COUNT_WIDTH-1:0]  bar_cnt;
  logic [PV_SUM_WIDTH-1:0] pv_base, pv_add;
  logic [V_SUM_WIDTH-1:0]  v_base, v_add;
  logic [PV_SUM_WIDTH:0]   pv_wide;
  logic [V_SUM_WIDTH:0]    v_wide;
  logic [COUNT_WIDTH-1:0]  cnt_base;
  logic                    take, div_start, div_done;
  logic [PRICE_WIDTH-1:0]  div_q;

  assign q_ready = (state == ST_IDLE);
  assign take = q_valid && q_ready;
  assign pv_base = q_first ? '0 : pv_sum;
  assign v_base = q_first ? '0 : v_sum;
  assign cnt_base = q_first ? '0 : bar_cnt;
  assign pv_add = PV_SUM_WIDTH'(q_pv);
  assign v_add = V_SUM_WIDTH'(q_vol);
  assign pv_wide = {1'b0, pv_base} + {1'b0, pv_add};
  assign v_wide = {1'b0, v_base} + {1'b0, v_add};

  rvwap_div #(.PRICE_WIDTH(PRICE_WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(pv_sum), .divisor(v_sum),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pv_sum    <= '0;
      v_sum     <= '0;
      last_avg  <= '0;
      bar_cnt   <= '0;
      div_start <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      div_start <= take && (v_wide != '0);
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            pv_sum  <= pv_wide[PV_SUM_WIDTH] ? '1 : pv_wide[PV_SUM_WIDTH-1:0];
            v_sum   <= v_wide[V_SUM_WIDTH] ? '1 : v_wide[V_SUM_WIDTH-1:0];
            bar_cnt <= (cnt_base == '1) ? cnt_base : cnt_base + COUNT_WIDTH'(1);
            if (q_first) last_avg <= '0;
            if (v_wide != '0) begin
              state <= ST_DIV;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            last_avg <= div_q;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.average_price <= last_avg;
            res.bars_in_range <= bar_cnt;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (res.valid && res.ready && !(state == ST_OUT)) res.valid <= 1'b0;
    end
  end
endmodule

@@ rtl/core/running_vwap.sv @@
// Running volume weighted average price over ranges of bars.
// Bars enter on a valid/ready channel; each bar yields one result transaction.
// A front stage forms typical price times volume and feeds a two-entry queue.
// The back part updates the saturating sums and the bar count, then divides
// the sums with a restoring divider that retires one quotient bit per cycle.
// A bar with first_bar set clears the sums, count and held average first.
// While no volume has traded the held average (zero at range start) repeats.
// The back part takes no new bar until the divider has run its 64 iterations
// (skipped when no volume has traded) and the result is in the output register.
// The front accepts up to three bars ahead while the back divides.
// Reset clears the sums, count, queue and the output valid flag.
// When the receiver stalls the result holds in the output register and the
// back part waits; the front keeps filling its queue until full.
module running_vwap #(
  parameter int PRICE_WIDTH  = rvwap_pkg::PRICE_WIDTH_DEF,
  parameter int VOLUME_WIDTH = rvwap_pkg::VOLUME_WIDTH_DEF,
  parameter int COUNT_WIDTH  = rvwap_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  rvwap_bar_if.sink bar,
  rvwap_res_if.source res
);
  import rvwap_pkg::*;
  logic q_valid, q_ready, q_first;
  logic [PRICE_WIDTH+VOLUME_WIDTH-1:0] q_pv;
  logic [VOLUME_WIDTH-1:0] q_vol;

  rvwap_front #(.PRICE_WIDTH(PRICE_WIDTH), .VOLUME_WIDTH(VOLUME_WIDTH)) u_front (
    .clk(clk), .rst(rst), .bar(bar), .q_valid(q_valid), .q_ready(q_ready),
    .q_pv(q_pv), .q_vol(q_vol), .q_first(q_first)
  );

  rvwap_back #(.PRICE_WIDTH(PRICE_WIDTH), .VOLUME_WIDTH(VOLUME_WIDTH),
               .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_pv(q_pv),
    .q_vol(q_vol), .q_first(q_first), .res(res)
  );
endmodule

@@ tb/tb_running_vwap.sv @@
// Testbench for running_vwap: drives bars, predicts average price and bar count.
// Depends on rvwap_pkg, rvwap_if.sv and the running_vwap RTL.
`timescale 1ns / 100ps

module tb;
  import rvwap_pkg::*;

  localparam int PW = PRICE_WIDTH_DEF;
  localparam int VW = VOLUME_WIDTH_DEF;
  localparam int CW = COUNT_WIDTH_DEF;

  typedef struct packed {
    logic [PW-1:0] avg;
    logic [CW-1:0] count;
  } vwap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic stall_free = 1'b0;
  int   mismatches = 0;

  rvwap_bar_if #(.PW(PW), .VW(VW)) bar ();
  rvwap_res_if #(.PW(PW), .CW(CW)) res ();

  running_vwap u_dut (.clk(clk), .rst(rst), .bar(bar), .res(res));

  logic [PV_SUM_WIDTH-1:0] pv_sum;
  logic [V_SUM_WIDTH-1:0]  vol_sum;
  logic [PW-1:0]           held_avg;
  logic [CW-1:0]           bar_count;
  vwap_result_t            expected_q[$];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("** running_vwap: FAILED **");
    $finish;
  end

  task automatic predict_vwap(input logic [PW-1:0] hi, input logic [PW-1:0] lo,
                              input logic [PW-1:0] cl, input logic [VW-1:0] vol,
                              input logic first);
    logic [PW+1:0]           typical;
    logic [PV_SUM_WIDTH:0]   pv_next;
    logic [V_SUM_WIDTH:0]    v_next;
    logic [PV_SUM_WIDTH-1:0] quot;
    vwap_result_t            r;
    if (first) begin
      pv_sum = '0;
      vol_sum = '0;
      held_avg = '0;
      bar_count = '0;
    end
    typical = ({2'b0, hi} + {2'b0, lo} + {2'b0, cl}) / (PW+2)'(3);
    pv_next = {1'b0, pv_sum} + (PV_SUM_WIDTH+1)'(typical) * (PV_SUM_WIDTH+1)'(vol);
    pv_sum = pv_next[PV_SUM_WIDTH] ? '1 : pv_next[PV_SUM_WIDTH-1:0];
    v_next = {1'b0, vol_sum} + (V_SUM_WIDTH+1)'(vol);
    vol_sum = v_next[V_SUM_WIDTH] ? '1 : v_next[V_SUM_WIDTH-1:0];
    if (vol_sum != '0) begin
      quot = pv_sum / PV_SUM_WIDTH'(vol_sum);
      held_avg = (quot > PV_SUM_WIDTH'({PW{1'b1}})) ? '1 : quot[PW-1:0];
    end
    if (bar_count != '1) bar_count++;
    r.avg = held_avg;
    r.count = bar_count;
    expected_q.push_back(r);
  endtask

  task automatic send_bar(input logic [PW-1:0] hi, input logic [PW-1:0] lo,
                          input logic [PW-1:0] cl, input logic [VW-1:0] vol,
                          input logic first);
    while (!stall_free && $urandom_range(99) < 20) begin
      bar.valid <= 1'b0;
      @(posedge clk);
    end
    bar.valid <= 1'b1;
    bar.high_price <= hi;
    bar.low_price <= lo;
    bar.close_price <= cl;
    bar.bar_volume <= vol;
    bar.first_bar <= first;
    @(negedge clk);
    while (!bar.ready) @(negedge clk);
    @(posedge clk);
    predict_vwap(hi, lo, cl, vol, first);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= stall_free || ($urandom_range(99) >= 20);
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result avg=%h count=%0d", $time,
                   res.average_price, res.bars_in_range);
          mismatches++;
        end else begin
          if (res.average_price !== expected_q[0].avg) begin
            $display("%0t: average_price expected %h actual %h", $time,
                     expected_q[0].avg, res.average_price);
            mismatches++;
          end
          if (res.bars_in_range !== expected_q[0].count) begin
            $display("%0t: bars_in_range expected %0d actual %0d", $time,
                     expected_q[0].count, res.bars_in_range);
            mismatches++;
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  function automatic logic [PW-1:0] rand_price();
    case ($urandom_range(3))
      0: return PW'($urandom_range(255));
      1: return {PW{1'b1}} - PW'($urandom_range(255));
      default: return PW'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_volume();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return VW'($urandom_range(1000));
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_bar('0, '0, '0, '0, 1'b0);
    send_bar(24'h000300, 24'h000100, 24'h000200, '0, 1'b0);
    send_bar(24'h000300, 24'h000100, 24'h000200, 24'd10, 1'b0);
    send_bar(24'h000A00, 24'h000500, 24'h000700, '0, 1'b0);
    send_bar(24'h000001, 24'h000001, 24'h000000, 24'd7, 1'b0);
    send_bar('1, '1, '1, '1, 1'b1);
    send_bar('1, '0, '1, 24'h555555, 1'b0);
    send_bar(24'h123456, 24'hABCDEF, 24'h00FF00, 24'hAAAAAA, 1'b1);
    send_bar('0, '0, '0, '1, 1'b1);
    send_bar('1, '1, '1, 24'd1, 1'b0);
  endtask

  task automatic test_saturation();
    send_bar('1, '1, '1, '1, 1'b1);
    repeat (20) send_bar('1, '1, '1, '1, 1'b0);
    send_bar(24'h000100, 24'h000100, 24'h000100, '1, 1'b0);
  endtask

  task automatic test_random_ranges();
    int len;
    repeat (13) begin
      len = int'($urandom_range(15, 1));
      send_bar(rand_price(), rand_price(), rand_price(), rand_volume(), 1'b1);
      repeat (len) begin
        send_bar(rand_price(), rand_price(), rand_price(), rand_volume(),
                 $urandom_range(30) == 0);
      end
    end
  endtask

  initial begin
    int wait_cycles;
    bar.valid = 1'b0;
    bar.high_price = '0;
    bar.low_price = '0;
    bar.close_price = '0;
    bar.bar_volume = '0;
    bar.first_bar = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_ranges();
    stall_free = 1'b1;
    test_random_ranges();
    stall_free = 1'b0;
    test_saturation();
    test_random_ranges();
    bar.valid <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** running_vwap: PASSED **");
    end else begin
      $display("** running_vwap: FAILED **");
    end
    $finish;
  end
endmodule
